>>> rtl/smm_pkg.sv
`timescale 1ns / 1ps

package smm_pkg;

    // Default geometry and number format
    localparam int MAX_DIM_DEF   = 4;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int POS_W      = 2;
    localparam int VAL_W      = 32;
    localparam int DIM_W      = 3;
    localparam int THR_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;
    localparam logic [THR_W-1:0] THR_RESET = 16'd0;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DIMENSION = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLUSH     = 1'd1;

    // Command codes; the fourth code does nothing
    typedef enum logic [CMD_W-1:0] {
        CMD_WR_A    = 2'd0,
        CMD_WR_B    = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    // Tag that travels with each operand pair down the MAC pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_tag;

endpackage

>>> rtl/square_matrix_multiply.sv
`timescale 1ns / 1ps

// Square matrix product engine. Each input word either loads one element of
// matrix A (cmd 0) or matrix B (cmd 1) at row/col, or (cmd 2) computes
// C = A x B over the active dimension and emits it row by row, one output word
// per element, with o_last set on the final element. Values are signed Q16.16;
// each element product is formed at 64 bits and shifted right arithmetically,
// the shifted products are summed exactly, the sum saturates to 32 bits and is
// flushed to zero when its magnitude is at or below the flush threshold.
// A compute walks every multiply-accumulate through a single shared 32x32
// multiplier and accumulator: per element it issues one operand pair (one word
// from each matrix store) per cycle, then waits until the sum has passed the
// pipeline and been handed to the output register, which the sink's stall can
// hold up. The input is stalled for the whole compute; the block returns to
// accepting words once the final element sits in the output register.
// Elements must be written before a compute reads them.
module square_matrix_multiply #(
    parameter int MAX_DIM   = smm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = smm_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [smm_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [smm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input words
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [smm_pkg::CMD_W-1:0]             i_cmd,
    input  logic [smm_pkg::POS_W-1:0]             i_row,
    input  logic [smm_pkg::POS_W-1:0]             i_col,
    input  logic signed [smm_pkg::VAL_W-1:0]      i_value,
    // output words
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [smm_pkg::POS_W-1:0]             o_out_row,
    output logic [smm_pkg::POS_W-1:0]             o_out_col,
    output logic signed [smm_pkg::VAL_W-1:0]      o_out_value,
    output logic                                  o_last
);

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_DIM);
    localparam int MAG_W  = smm_pkg::VAL_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state                          r_state;
    logic [smm_pkg::DIM_W-1:0]       r_dimension;
    logic [smm_pkg::THR_W-1:0]       r_flush;
    logic [IDX_W-1:0]                r_lim;
    logic [IDX_W-1:0]                r_i;
    logic [IDX_W-1:0]                r_j;
    logic [IDX_W-1:0]                r_k;
    logic                            r_have;
    smm_pkg::t_tag                   r_tag1;

    logic                            r_o_valid;
    logic [smm_pkg::POS_W-1:0]       r_o_row;
    logic [smm_pkg::POS_W-1:0]       r_o_col;
    logic signed [smm_pkg::VAL_W-1:0] r_o_value;
    logic                            r_o_last;

    logic                            in_acc;
    logic                            wr_ok;
    logic                            wr_a;
    logic                            wr_b;
    logic [ADDR_W-1:0]               wr_addr;
    logic [ADDR_W-1:0]               rd_addr_a;
    logic [ADDR_W-1:0]               rd_addr_b;
    logic                            issue;
    smm_pkg::t_tag                   n_tag;
    logic [IDX_W-1:0]                n_lim;
    logic signed [smm_pkg::VAL_W-1:0] rd_a;
    logic signed [smm_pkg::VAL_W-1:0] rd_b;
    logic                            mac_done;
    logic signed [smm_pkg::VAL_W-1:0] mac_sum;
    logic [MAG_W-1:0]                mag;
    logic signed [smm_pkg::VAL_W-1:0] n_value;
    logic                            out_free;
    logic                            load;
    logic                            last_elem;

    // Handshake: take words only in idle
    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;

    // Writes outside the store are dropped
    assign wr_ok   = (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);
    assign wr_a    = in_acc && wr_ok && (i_cmd == smm_pkg::CMD_WR_A);
    assign wr_b    = in_acc && wr_ok && (i_cmd == smm_pkg::CMD_WR_B);
    assign wr_addr = ADDR_W'(i_row) * STRIDE + ADDR_W'(i_col);

    // Operand addresses: A[i][k] and B[k][j]
    assign rd_addr_a = ADDR_W'(r_i) * STRIDE + ADDR_W'(r_k);
    assign rd_addr_b = ADDR_W'(r_k) * STRIDE + ADDR_W'(r_j);
    assign issue     = (r_state == S_ISSUE);

    always_comb begin
        n_tag.vld   = issue;
        n_tag.first = (r_k == '0);
        n_tag.last  = (r_k == r_lim);
    end

    // Active dimension less one; zero acts as one, large values clamp
    always_comb begin
        if (r_dimension == '0) begin
            n_lim = '0;
        end else if (int'(r_dimension) > MAX_DIM) begin
            n_lim = IDX_W'(MAX_DIM - 1);
        end else begin
            n_lim = IDX_W'(r_dimension - 3'd1);
        end
    end

    // Flush: magnitude at or below threshold becomes zero
    always_comb begin
        if (mac_sum[smm_pkg::VAL_W-1]) begin
            mag = MAG_W'(0) - {1'b1, mac_sum};
        end else begin
            mag = {1'b0, mac_sum};
        end
        if (mag <= MAG_W'(r_flush)) begin
            n_value = '0;
        end else begin
            n_value = mac_sum;
        end
    end

    assign out_free  = !r_o_valid || !i_stall;
    assign load      = (r_state == S_WAIT) && r_have && out_free;
    assign last_elem = (r_i == r_lim) && (r_j == r_lim);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= smm_pkg::DIM_RESET;
            r_flush     <= smm_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                smm_pkg::CFG_DIMENSION: r_dimension <= i_cfg_data[smm_pkg::DIM_W-1:0];
                smm_pkg::CFG_FLUSH:     r_flush     <= i_cfg_data[smm_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_have    <= 1'b0;
            r_tag1    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // tag lines up with the registered store read
            r_tag1 <= n_tag;

            if (load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_cmd == smm_pkg::CMD_COMPUTE)) begin
                        r_lim   <= n_lim;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_k == r_lim) begin
                        r_k     <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (mac_done) begin
                        r_have <= 1'b1;
                    end
                    if (load) begin
                        r_have <= 1'b0;
                        if (last_elem) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ISSUE;
                            if (r_j == r_lim) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_row   <= smm_pkg::POS_W'(r_i);
            r_o_col   <= smm_pkg::POS_W'(r_j);
            r_o_value <= n_value;
            r_o_last  <= last_elem;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_out_value = r_o_value;
    assign o_last      = r_o_last;

    smm_store #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_a      (wr_a),
        .i_wr_b      (wr_b),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_value),
        .i_rd_en     (issue),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    smm_mac #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag1),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .o_done  (mac_done),
        .o_sum   (mac_sum)
    );

    // Operands only follow an issue cycle
    a_tag_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag1.vld |-> $past(r_state == S_ISSUE))
        else $error("operand tag without issue");

    // A finished element arrives only while waiting and nothing is held
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_WAIT) && !r_have)
        else $error("element finished outside wait or overwrote held sum");

    // Held sum lives only in the wait state
    a_have_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_state == S_WAIT))
        else $error("held sum outside wait");

    // Handing over the final element ends the compute
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && last_elem) |=> (r_state == S_IDLE) && o_valid && o_last)
        else $error("final element did not end the compute");

endmodule

>>> rtl/smm_store.sv
`timescale 1ns / 1ps

module smm_store #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF,
    parameter int ADDR_W  = 4
) (
    input  logic                            i_clk,
    input  logic                            i_wr_a,
    input  logic                            i_wr_b,
    input  logic [ADDR_W-1:0]               i_wr_addr,
    input  logic signed [smm_pkg::VAL_W-1:0] i_wr_data,
    input  logic                            i_rd_en,
    input  logic [ADDR_W-1:0]               i_rd_addr_a,
    input  logic [ADDR_W-1:0]               i_rd_addr_b,
    output logic signed [smm_pkg::VAL_W-1:0] o_rd_a,
    output logic signed [smm_pkg::VAL_W-1:0] o_rd_b
);

    localparam int CELLS = MAX_DIM * MAX_DIM;

    logic signed [smm_pkg::VAL_W-1:0] r_mem_a [CELLS];
    logic signed [smm_pkg::VAL_W-1:0] r_mem_b [CELLS];
    logic signed [smm_pkg::VAL_W-1:0] r_rd_a;
    logic signed [smm_pkg::VAL_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, one word from each matrix per cycle while the read is enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem_a[i_rd_addr_a];
            r_rd_b <= r_mem_b[i_rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

>>> rtl/smm_mac.sv
`timescale 1ns / 1ps

module smm_mac #(
    parameter int MAX_DIM   = smm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = smm_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  smm_pkg::t_tag                    i_tag,
    input  logic signed [smm_pkg::VAL_W-1:0] i_a,
    input  logic signed [smm_pkg::VAL_W-1:0] i_b,
    output logic                             o_done,
    output logic signed [smm_pkg::VAL_W-1:0] o_sum
);

    localparam int PROD_W = 2 * smm_pkg::VAL_W;
    localparam int ACC_W  = PROD_W - FRAC_BITS + $clog2(MAX_DIM) + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd2147483648));

    logic signed [PROD_W-1:0]         r_prod;
    smm_pkg::t_tag                    r_tag;
    logic signed [ACC_W-1:0]          r_acc;
    logic                             r_acc_done;
    logic signed [smm_pkg::VAL_W-1:0] r_sum;
    logic                             r_done;

    logic signed [PROD_W-1:0] shifted;
    logic signed [ACC_W-1:0]  term;

    // Shift right arithmetically: rounds toward minus infinity
    assign shifted = r_prod >>> FRAC_BITS;
    assign term    = ACC_W'(shifted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag      <= '0;
            r_acc_done <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_tag      <= i_tag;
            r_acc_done <= r_tag.vld && r_tag.last;
            r_done     <= r_acc_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.vld) begin
            r_prod <= i_a * i_b;
        end
        if (r_tag.vld) begin
            r_acc <= r_tag.first ? term : r_acc + term;
        end
        // Saturate once per element; hold until the next element completes
        if (r_acc_done) begin
            if (r_acc > SAT_HI) begin
                r_sum <= SAT_HI[smm_pkg::VAL_W-1:0];
            end else if (r_acc < SAT_LO) begin
                r_sum <= SAT_LO[smm_pkg::VAL_W-1:0];
            end else begin
                r_sum <= r_acc[smm_pkg::VAL_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule
